@@ sv/scfr_pkg.sv @@
// Shared types and constants for the serial command frame receiver.
// No dependencies; most other files refer to this package by scoped names.
`timescale 1ns / 1ps

package scfr_pkg;

	localparam logic [7:0] HDR        = 8'd255;
	localparam logic [7:0] INS_PING   = 8'd1;
	localparam logic [7:0] INS_READ   = 8'd2;
	localparam logic [7:0] INS_HOME   = 8'd5;
	localparam logic [7:0] ERR_CODE   = 8'd6;
	localparam logic [7:0] SHORT_LEN  = 8'd3;
	localparam logic [7:0] READ_LEN   = 8'd6;
	localparam logic [7:0] ACK_PARAM  = 8'd1;
	localparam logic [7:0] ERR_CSUM   = ~(SHORT_LEN + ERR_CODE + ACK_PARAM);
	localparam logic [7:0] HOME_CSUM  = ~(SHORT_LEN + INS_HOME + ACK_PARAM);

	localparam int CFG_W    = 16;
	localparam int CFG_IDXW = 1;
	localparam logic [CFG_IDXW-1:0] REG_POS_X = 1'd0;
	localparam logic [CFG_IDXW-1:0] REG_POS_Y = 1'd1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// reply byte index: 0..8
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] LAST_SHORT = 4'd5;
	localparam logic [IDX_W-1:0] LAST_READ  = 4'd8;

	typedef enum logic [3:0] {
		PH_HUNT0 = 4'b0001,
		PH_HUNT1 = 4'b0010,
		PH_LEN   = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		K_ERR  = 2'd0,
		K_PING = 2'd1,
		K_READ = 2'd2,
		K_HOME = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] len;
		logic [7:0] p0;
		logic [7:0] p1;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic full;
		logic valid;
		cmd_t cmd;
	} fifo_stat_t;

endpackage

@@ sv/scfr_if.sv @@
// Valid/ready channel interfaces for received bytes and reply bytes.
// Depends on nothing.
`timescale 1ns / 1ps

interface scfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;
	modport source (output valid, output tx_byte, output last_byte, input ready);
	modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

@@ sv/serial_command_frame_receiver_core.sv @@
// Top level of the serial command frame receiver: front end, command queue, reply generator.
// Depends on scfr_pkg, scfr_if, scfr_front, scfr_cmd_fifo and scfr_back.
//
//   channel | dir | payload                 | beat
//   rx      | in  | rx_byte[7:0]            | one received byte
//   tx      | out | tx_byte[7:0], last_byte | one reply byte, last_byte on final
//   cfg     | in  | cfg_idx, cfg_wdata[15:0]| register write when cfg_we
//
// One rx beat per cycle while the 4-entry command queue has room (rx.ready = queue not full).
// A reply leaves as 6 or 9 tx beats, one per cycle unless tx stalls, via cmd_q and byte_q.
// A stalled tx holds the output register; the front keeps accepting until the queue fills.
// Async active-low reset: hunting the header, queue empty, positions at 43707 and 52445.
`timescale 1ns / 1ps

module serial_command_frame_receiver_core (
	input  logic                          clk,
	input  logic                          arst_n,
	scfr_rx_if.sink                       rx,
	scfr_tx_if.source                     tx,
	input  logic                          cfg_we,
	input  logic [scfr_pkg::CFG_IDXW-1:0] cfg_idx,
	input  logic [scfr_pkg::CFG_W-1:0]    cfg_wdata
);

	scfr_pkg::push_t      push;
	scfr_pkg::fifo_stat_t stat;
	logic                 pop;

	scfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.fifo_full (stat.full),
		.push      (push)
	);

	scfr_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (stat)
	);

	scfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.pop       (pop),
		.tx        (tx)
	);

endmodule

@@ sv/scfr_front.sv @@
// Front end: frame hunt, length/body tracking, checksum check and instruction decode.
// Depends on scfr_pkg and scfr_rx_if; pushes reply commands into scfr_cmd_fifo.
`timescale 1ns / 1ps

module scfr_front (
	input  logic               clk,
	input  logic               arst_n,
	scfr_rx_if.sink            rx,
	input  logic               fifo_full,
	output scfr_pkg::push_t    push
);

	scfr_pkg::phase_t phase_q;
	logic [7:0] len_q, left_q, sum_q, instr_q, p0_q, p1_q;

	logic [7:0] b, pos, left_nx, instr_nx, p0_nx, p1_nx;
	logic       acc;

	assign rx.ready = !fifo_full;
	assign acc      = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign pos      = len_q - left_q;
	assign left_nx  = left_q - 8'd1;
	assign instr_nx = (pos == 8'd0) ? b : instr_q;
	assign p0_nx    = (pos == 8'd1) ? b : p0_q;
	assign p1_nx    = (pos == 8'd2) ? b : p1_q;

	always_comb begin
		push.valid    = 1'b0;
		push.cmd.kind = scfr_pkg::K_ERR;
		push.cmd.len  = len_q;
		push.cmd.p0   = p0_nx;
		push.cmd.p1   = p1_nx;
		if (acc) begin
			case (phase_q)
				scfr_pkg::PH_LEN: begin
					// zero length is reported as a checksum error
					push.valid = (b == 8'd0);
				end
				scfr_pkg::PH_BODY: begin
					if (left_nx == 8'd0) begin
						if (~sum_q != b) begin
							push.valid = 1'b1;
						end else begin
							case (instr_nx)
								scfr_pkg::INS_PING: begin
									push.valid    = 1'b1;
									push.cmd.kind = scfr_pkg::K_PING;
								end
								scfr_pkg::INS_READ: begin
									push.valid    = 1'b1;
									push.cmd.kind = scfr_pkg::K_READ;
								end
								scfr_pkg::INS_HOME: begin
									push.valid    = (p0_nx == 8'd0);
									push.cmd.kind = scfr_pkg::K_HOME;
								end
								default: push.valid = 1'b0;
							endcase
						end
					end
				end
				default: push.valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scfr_pkg::PH_HUNT0;
			len_q   <= '0;
			left_q  <= '0;
			sum_q   <= '0;
			instr_q <= '0;
			p0_q    <= '0;
			p1_q    <= '0;
		end else if (acc) begin
			case (phase_q)
				scfr_pkg::PH_HUNT0: begin
					if (b == scfr_pkg::HDR) phase_q <= scfr_pkg::PH_HUNT1;
				end
				scfr_pkg::PH_HUNT1: begin
					phase_q <= (b == scfr_pkg::HDR) ? scfr_pkg::PH_LEN : scfr_pkg::PH_HUNT0;
				end
				scfr_pkg::PH_LEN: begin
					len_q   <= b;
					left_q  <= b;
					sum_q   <= b;
					instr_q <= '0;
					p0_q    <= '0;
					p1_q    <= '0;
					phase_q <= (b == 8'd0) ? scfr_pkg::PH_HUNT0 : scfr_pkg::PH_BODY;
				end
				scfr_pkg::PH_BODY: begin
					instr_q <= instr_nx;
					p0_q    <= p0_nx;
					p1_q    <= p1_nx;
					left_q  <= left_nx;
					if (left_nx != 8'd0) sum_q <= sum_q + b;
					else phase_q <= scfr_pkg::PH_HUNT0;
				end
				default: phase_q <= scfr_pkg::PH_HUNT0;
			endcase
		end
	end

endmodule

@@ sv/scfr_cmd_fifo.sv @@
// Small command queue between front end and reply generator.
// Depends on scfr_pkg.
`timescale 1ns / 1ps

module scfr_cmd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  scfr_pkg::push_t        push,
	input  logic                   pop,
	output scfr_pkg::fifo_stat_t   stat
);

	scfr_pkg::cmd_t mem_q [scfr_pkg::FIFO_DEPTH];
	logic [scfr_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [scfr_pkg::FIFO_CW-1:0] cnt_q;
	logic do_pop;

	assign stat.full  = (cnt_q == scfr_pkg::FIFO_CW'(scfr_pkg::FIFO_DEPTH));
	assign stat.valid = (cnt_q != '0);
	assign stat.cmd   = mem_q[rd_q];
	assign do_pop     = pop && stat.valid;

	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_q] <= push.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			case ({push.valid, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/scfr_back.sv @@
// Reply generator: serializes one queued command into reply beats, holds the position registers.
// Depends on scfr_pkg and scfr_tx_if; pops commands from scfr_cmd_fifo.
`timescale 1ns / 1ps

module scfr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [scfr_pkg::CFG_IDXW-1:0] cfg_idx,
	input  logic [scfr_pkg::CFG_W-1:0]    cfg_wdata,
	input  scfr_pkg::fifo_stat_t          stat,
	output logic                          pop,
	scfr_tx_if.source                     tx
);

	logic [15:0] pos_x_q, pos_y_q;
	scfr_pkg::cmd_t cmd_q;
	logic       busy_q;
	logic [scfr_pkg::IDX_W-1:0] idx_q, last_idx;
	logic       valid_q, last_q;
	logic [7:0] byte_q;

	logic       out_free, emit, is_last;
	logic [7:0] rd_csum, nx_byte;

	assign tx.valid     = valid_q;
	assign tx.tx_byte   = byte_q;
	assign tx.last_byte = last_q;

	assign out_free = !valid_q || tx.ready;
	assign emit     = busy_q && out_free;
	assign last_idx = (cmd_q.kind == scfr_pkg::K_READ) ? scfr_pkg::LAST_READ
	                                                   : scfr_pkg::LAST_SHORT;
	assign is_last  = (idx_q == last_idx);
	assign pop      = stat.valid && (!busy_q || (emit && is_last));

	assign rd_csum = ~(scfr_pkg::READ_LEN + scfr_pkg::INS_READ + pos_x_q[15:8] + pos_x_q[7:0]
	                   + pos_y_q[15:8] + pos_y_q[7:0]);

	always_comb begin
		nx_byte = scfr_pkg::HDR;
		case (cmd_q.kind)
			scfr_pkg::K_PING: begin
				case (idx_q)
					4'd2:    nx_byte = cmd_q.len;
					4'd3:    nx_byte = scfr_pkg::INS_PING;
					4'd4:    nx_byte = cmd_q.p0;
					4'd5:    nx_byte = cmd_q.p1;
					default: nx_byte = scfr_pkg::HDR;
				endcase
			end
			scfr_pkg::K_READ: begin
				case (idx_q)
					4'd2:    nx_byte = scfr_pkg::READ_LEN;
					4'd3:    nx_byte = scfr_pkg::INS_READ;
					4'd4:    nx_byte = pos_x_q[15:8];
					4'd5:    nx_byte = pos_x_q[7:0];
					4'd6:    nx_byte = pos_y_q[15:8];
					4'd7:    nx_byte = pos_y_q[7:0];
					4'd8:    nx_byte = rd_csum;
					default: nx_byte = scfr_pkg::HDR;
				endcase
			end
			scfr_pkg::K_HOME: begin
				case (idx_q)
					4'd2:    nx_byte = scfr_pkg::SHORT_LEN;
					4'd3:    nx_byte = scfr_pkg::INS_HOME;
					4'd4:    nx_byte = scfr_pkg::ACK_PARAM;
					4'd5:    nx_byte = scfr_pkg::HOME_CSUM;
					default: nx_byte = scfr_pkg::HDR;
				endcase
			end
			default: begin
				case (idx_q)
					4'd2:    nx_byte = scfr_pkg::SHORT_LEN;
					4'd3:    nx_byte = scfr_pkg::ERR_CODE;
					4'd4:    nx_byte = scfr_pkg::ACK_PARAM;
					4'd5:    nx_byte = scfr_pkg::ERR_CSUM;
					default: nx_byte = scfr_pkg::HDR;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= 16'd43707;
			pos_y_q <= 16'd52445;
		end else if (cfg_we) begin
			case (cfg_idx)
				scfr_pkg::REG_POS_X: pos_x_q <= cfg_wdata;
				scfr_pkg::REG_POS_Y: pos_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= stat.cmd;
		if (emit) begin
			byte_q <= nx_byte;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			// next command is taken on the same cycle the last beat is loaded
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
				if (is_last) busy_q <= 1'b0;
			end
			if (emit) valid_q <= 1'b1;
			else if (tx.ready) valid_q <= 1'b0;
		end
	end

endmodule

@@ sv/scfr_checker.sv @@
// Port-level checks for the serial command frame receiver, bound to the top level.
// Depends on serial_command_frame_receiver_core port names.
`timescale 1ns / 1ps

module scfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_ready,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_byte,
	input logic       last_byte
);

	// stalled beat holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(last_byte))
		else $error("tx beat changed while stalled");

	a_reset_idle: assert property (@(posedge clk) $rose(arst_n) |-> !tx_valid)
		else $error("tx valid right after reset");

	// queue can only fill while a reply is being delivered
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> tx_valid)
		else $error("rx stalled with no reply pending");

endmodule

bind serial_command_frame_receiver_core scfr_checker u_scfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_ready  (rx.ready),
	.tx_valid  (tx.valid),
	.tx_ready  (tx.ready),
	.tx_byte   (tx.tx_byte),
	.last_byte (tx.last_byte)
);

@@ dv/scfr_reply_checker.sv @@
// Scoreboard for the serial command frame receiver: tracks the frame parser on accepted
// rx beats, queues the reply bytes it should send, and compares every accepted tx beat.
// Depends on scfr_pkg and scfr_if.
`timescale 1ns / 1ps

module scfr_reply_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	scfr_rx_if                            rx,
	scfr_tx_if                            tx,
	input  logic                          cfg_we,
	input  logic [scfr_pkg::CFG_IDXW-1:0] cfg_idx,
	input  logic [scfr_pkg::CFG_W-1:0]    cfg_wdata,
	output int                            mismatches,
	output int                            pending
);

	localparam logic [15:0] POS_X_RESET = 16'd43707;
	localparam logic [15:0] POS_Y_RESET = 16'd52445;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_beat_t;

	reply_beat_t reply_bytes_due[$];
	reply_beat_t head;
	logic [15:0] pos_x, pos_y;
	scfr_pkg::phase_t ph;
	logic [7:0]  frm_len, left, sum, ins, par0, par1;
	int          errs;

	task automatic flag_error(input string msg);
		errs++;
		if (errs <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// r[0] goes out first; last set on byte n-1
	task automatic push_reply(input logic [8:0][7:0] r, input int n);
		reply_beat_t bt;
		int k;
		for (k = 0; k < n; k++) begin
			bt.data = r[k];
			bt.last = (k == n - 1);
			reply_bytes_due.push_back(bt);
		end
	endtask

	task automatic push_error_reply();
		logic [8:0][7:0] r;
		r = '0;
		r[0] = scfr_pkg::HDR;
		r[1] = scfr_pkg::HDR;
		r[2] = scfr_pkg::SHORT_LEN;
		r[3] = scfr_pkg::ERR_CODE;
		r[4] = scfr_pkg::ACK_PARAM;
		r[5] = scfr_pkg::ERR_CSUM;
		push_reply(r, 6);
	endtask

	task automatic decode_frame();
		logic [8:0][7:0] r;
		logic [7:0] s;
		r = '0;
		r[0] = scfr_pkg::HDR;
		r[1] = scfr_pkg::HDR;
		case (ins)
			scfr_pkg::INS_PING: begin
				r[2] = frm_len;
				r[3] = ins;
				r[4] = (frm_len >= 8'd2) ? par0 : 8'h00;
				r[5] = (frm_len >= 8'd3) ? par1 : 8'h00;
				push_reply(r, 6);
			end
			scfr_pkg::INS_READ: begin
				r[2] = scfr_pkg::READ_LEN;
				r[3] = scfr_pkg::INS_READ;
				r[4] = pos_x[15:8];
				r[5] = pos_x[7:0];
				r[6] = pos_y[15:8];
				r[7] = pos_y[7:0];
				s = r[2] + r[3] + r[4] + r[5] + r[6] + r[7];
				r[8] = ~s;
				push_reply(r, 9);
			end
			scfr_pkg::INS_HOME: begin
				// param missing on short frames reads as zero
				if (frm_len < 8'd2 || par0 == 8'h00) begin
					r[2] = scfr_pkg::SHORT_LEN;
					r[3] = scfr_pkg::INS_HOME;
					r[4] = scfr_pkg::ACK_PARAM;
					r[5] = scfr_pkg::HOME_CSUM;
					push_reply(r, 6);
				end
			end
			default: ;
		endcase
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		logic [7:0] at;
		logic [7:0] want_sum;
		case (ph)
			scfr_pkg::PH_HUNT0: begin
				if (b == scfr_pkg::HDR)
					ph = scfr_pkg::PH_HUNT1;
			end
			scfr_pkg::PH_HUNT1: ph = (b == scfr_pkg::HDR) ? scfr_pkg::PH_LEN
				: scfr_pkg::PH_HUNT0;
			scfr_pkg::PH_LEN: begin
				frm_len = b;
				left    = b;
				sum     = b;
				ins     = 8'h00;
				par0    = 8'h00;
				par1    = 8'h00;
				if (b == 8'h00) begin
					ph = scfr_pkg::PH_HUNT0;
					push_error_reply();
				end else begin
					ph = scfr_pkg::PH_BODY;
				end
			end
			scfr_pkg::PH_BODY: begin
				at = frm_len - left;
				if (at == 8'd0)
					ins = b;
				else if (at == 8'd1)
					par0 = b;
				else if (at == 8'd2)
					par1 = b;
				left = left - 8'd1;
				if (left != 8'd0) begin
					sum = sum + b;
				end else begin
					// checksum byte also lands in ins/par when the frame is short
					ph = scfr_pkg::PH_HUNT0;
					want_sum = ~sum;
					if (want_sum != b)
						push_error_reply();
					else
						decode_frame();
				end
			end
			default: ph = scfr_pkg::PH_HUNT0;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_bytes_due.delete();
			pos_x      = POS_X_RESET;
			pos_y      = POS_Y_RESET;
			ph         = scfr_pkg::PH_HUNT0;
			frm_len    = 8'h00;
			left       = 8'h00;
			sum        = 8'h00;
			ins        = 8'h00;
			par0       = 8'h00;
			par1       = 8'h00;
			errs       = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (tx.valid && tx.ready) begin
				if (reply_bytes_due.size() == 0) begin
					flag_error($sformatf("unexpected tx beat: byte %0d last %0b",
						tx.tx_byte, tx.last_byte));
				end else begin
					head = reply_bytes_due.pop_front();
					if (head.data !== tx.tx_byte || head.last !== tx.last_byte)
						flag_error($sformatf(
							"tx beat mismatch: expected byte %0d last %0b, got byte %0d last %0b",
							head.data, head.last, tx.tx_byte, tx.last_byte));
				end
			end
			if (cfg_we) begin
				if (cfg_idx == scfr_pkg::REG_POS_X)
					pos_x = cfg_wdata;
				else if (cfg_idx == scfr_pkg::REG_POS_Y)
					pos_y = cfg_wdata;
			end
			if (rx.valid && rx.ready)
				parse_rx_byte(rx.rx_byte);
			mismatches <= errs;
			pending    <= reply_bytes_due.size();
		end
	end

endmodule

@@ dv/serial_command_frame_receiver_core_test.sv @@
// Top of the frame receiver testbench: clock, reset, frame stimulus, tx stalls, verdict.
// Depends on scfr_pkg, scfr_if, scfr_reply_checker and serial_command_frame_receiver_core.
`timescale 1ns / 1ps

module serial_command_frame_receiver_core_test;

	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_BYTES  = 96;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [scfr_pkg::CFG_IDXW-1:0] cfg_idx;
	logic [scfr_pkg::CFG_W-1:0]    cfg_wdata;
	int                            mismatches;
	int                            pending;
	logic [7:0]                    rx_bytes[$];

	scfr_rx_if rx_ch ();
	scfr_tx_if tx_ch ();

	serial_command_frame_receiver_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.tx        (tx_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	scfr_reply_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.tx         (tx_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// header, length, body with the checksum as last body byte; bad flips checksum bits
	task automatic add_frame(input logic [7:0] len, input logic [7:0] ins,
			input logic [7:0] p0, input logic [7:0] p1, input bit bad);
		logic [7:0] s;
		logic [7:0] v;
		int k;
		rx_bytes.push_back(scfr_pkg::HDR);
		rx_bytes.push_back(scfr_pkg::HDR);
		rx_bytes.push_back(len);
		s = len;
		for (k = 0; k < len; k++) begin
			if (k == 0)
				v = ins;
			else if (k == 1)
				v = p0;
			else if (k == 2)
				v = p1;
			else
				v = 8'($urandom);
			if (k == len - 1)
				v = bad ? (~s ^ 8'($urandom_range(1, 255))) : ~s;
			else
				s = s + v;
			rx_bytes.push_back(v);
		end
	endtask

	task automatic add_random_traffic(input int count);
		int         sel;
		int         n;
		logic [7:0] len;
		logic [7:0] ins;
		logic [7:0] p0;
		while (rx_bytes.size() < count) begin
			sel = $urandom_range(0, 99);
			len = ($urandom_range(0, 79) == 0) ? 8'($urandom_range(9, 255))
				: 8'($urandom_range(1, 6));
			case ($urandom_range(0, 3))
				0: ins = scfr_pkg::INS_PING;
				1: ins = scfr_pkg::INS_READ;
				2: ins = scfr_pkg::INS_HOME;
				default: ins = 8'($urandom);
			endcase
			p0 = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
			if (sel < 75) begin
				add_frame(len, ins, p0, 8'($urandom), 1'b0);
			end else if (sel < 85) begin
				if ($urandom_range(0, 2) == 0)
					len = 8'h00;
				add_frame(len, ins, p0, 8'($urandom), 1'b1);
			end else if (sel < 92) begin
				rx_bytes.push_back(scfr_pkg::HDR);
				rx_bytes.push_back(8'($urandom_range(0, 254)));
			end else begin
				// line noise, 255s included
				n = $urandom_range(1, 4);
				repeat (n)
					rx_bytes.push_back(($urandom_range(0, 3) == 0) ? scfr_pkg::HDR
						: 8'($urandom));
			end
		end
	endtask

	task automatic drive_bytes(input bit steady);
		int burst;
		int gap;
		while (rx_bytes.size() != 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && rx_bytes.size() != 0) begin
				rx_ch.valid   <= 1'b1;
				rx_ch.rx_byte <= rx_bytes.pop_front();
				@(posedge clk);
				while (!rx_ch.ready)
					@(posedge clk);
				burst--;
			end
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			// valid drops for a gap and after the final beat
			if (gap != 0 || rx_bytes.size() == 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_positions(input logic [15:0] x, input logic [15:0] y);
		cfg_we    <= 1'b1;
		cfg_idx   <= scfr_pkg::REG_POS_X;
		cfg_wdata <= x;
		@(posedge clk);
		cfg_idx   <= scfr_pkg::REG_POS_Y;
		cfg_wdata <= y;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_random_phase(input bit steady);
		add_random_traffic(PHASE_BYTES);
		drive_bytes(steady);
		wait_idle();
	endtask

	// tx side: ready runs of random length broken by short stalls
	initial begin
		int run;
		tx_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 24);
			tx_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			run = $urandom_range(0, 4);
			if (run != 0) begin
				tx_ch.ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = scfr_pkg::REG_POS_X;
		cfg_wdata     = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, reset positions
		add_frame(8'd3, scfr_pkg::INS_PING, 8'h5A, 8'h00, 1'b0);
		add_frame(8'd2, scfr_pkg::INS_READ, 8'h00, 8'h00, 1'b0);
		add_frame(8'd3, scfr_pkg::INS_HOME, 8'h00, 8'h00, 1'b0);
		add_frame(8'd0, 8'h00, 8'h00, 8'h00, 1'b0);
		add_frame(8'd2, scfr_pkg::INS_PING, 8'h00, 8'h00, 1'b1);
		rx_bytes.push_back(scfr_pkg::HDR);
		rx_bytes.push_back(8'd7);
		add_frame(8'd1, 8'h00, 8'h00, 8'h00, 1'b0);
		drive_bytes(1'b0);
		wait_idle();

		run_random_phase(1'b0);
		write_positions(16'h0000, 16'h0000);
		run_random_phase(1'b0);
		write_positions(16'hFFFF, 16'hFFFF);
		run_random_phase(1'b1);
		write_positions(16'($urandom), 16'($urandom));
		run_random_phase(1'b0);
		write_positions(16'h0000, 16'hFFFF);
		run_random_phase(1'b0);

		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
sv/scfr_pkg.sv
sv/scfr_if.sv
sv/scfr_front.sv
sv/scfr_cmd_fifo.sv
sv/scfr_back.sv
sv/serial_command_frame_receiver_core.sv
sv/scfr_checker.sv
dv/scfr_reply_checker.sv
dv/serial_command_frame_receiver_core_test.sv
